@@ sv/dust_sensor_average_and_convert_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dust sensor average and convert block
// Each macro expects clk and rst_n in scope and reports through $error.
// ----------------------------------------------------------------------------
`ifndef DUST_SENSOR_AVERAGE_AND_CONVERT_ASSERT_SVH
`define DUST_SENSOR_AVERAGE_AND_CONVERT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property at every rising edge outside reset.
`define DSAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dsac assertion failed");

// Check that a condition implies another in the following cycle.
`define DSAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsac assertion failed");

`else

`define DSAC_ASSERT(lbl, prop)
`define DSAC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/dsac_pkg.sv @@
// ----------------------------------------------------------------------------
// dsac_pkg
// Widths, constants and state type of the dust sensor average and convert block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsac_pkg;

  localparam int WINDOW_LEN = 10;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int MV_W     = 16;
  localparam int RATIO_W  = 8;
  localparam int DENS_W   = 24;

  // Truncating divide by WINDOW_LEN as a multiply by a rounded-up reciprocal.
  // With a 20-bit shift the result is exact for every 16-bit sum.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int RECIP_W     = $clog2(RECIP + 1);

  localparam int REF_MV    = 3300;
  localparam int REF_MV_W  = 12;
  localparam int ADC_SHIFT = 12;
  localparam int DIVIDER   = 11;
  localparam int MV_MAX    = ((((2 ** SAMPLE_W) - 1) * REF_MV) / (2 ** ADC_SHIFT)) * DIVIDER;

  localparam logic [MV_W-1:0]    NO_DUST_RST = 16'd400;
  localparam logic [RATIO_W-1:0] RATIO_RST   = 8'd20;

  // Register select, taken from address bit 2
  localparam logic REG_NO_DUST = 1'b0;
  localparam logic REG_RATIO   = 1'b1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int IN_DW  = 16;
  localparam int OUT_DW = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_SCALE,
    ST_MV,
    ST_DENS
  } dsac_state_t;

endpackage

@@ sv/dust_sensor_average_and_convert.sv @@
// ----------------------------------------------------------------------------
// dust_sensor_average_and_convert
// Ten-sample moving average of a 12-bit reading, then millivolts and dust density.
// ----------------------------------------------------------------------------
// One item is in flight at a time: the sample ring memory is read at the
// accepting edge, then come the ring write and running sum update, the
// reciprocal multiply for the average, the two millivolt scaling multiplies
// and the density multiply, with which the result reaches the output register.
// The next item is taken once the sequencer is back in idle; a result left
// waiting in the output register holds the sequencer in its last step. The
// ring needs no clearing pass: entries not yet written since the first sample
// read as that sample.
`timescale 1ns / 1ps
`include "dust_sensor_average_and_convert_assert.svh"

module dust_sensor_average_and_convert
  import dsac_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_DW-1:0]    in_tdata,      // [11:0] sample
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_DW-1:0]   out_tdata,     // [11:0] raw_sample, [23:12] averaged,
                                             // [39:24] voltage_mv, [63:40] density_centi
  // Configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  // Control
  dsac_state_t state_r, state_nxt;
  logic        accept;
  logic        mem_we;
  logic        out_load;

  logic [SLOT_W-1:0]   slot_r;
  logic                wrapped_r;
  logic                first_pend_r;
  logic                out_valid_r;

  // Datapath
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] first_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] avg_r;
  logic [SAMPLE_W-1:0] scaled_r;
  logic [MV_W-1:0]     mv_r;
  logic [OUT_DW-1:0]   out_data_r;

  logic [SUM_W+RECIP_W-1:0]      avg_prod;
  logic [SAMPLE_W+REF_MV_W-1:0]  scale_prod;
  logic [MV_W-1:0]               mv_nxt;
  logic [MV_W-1:0]               mv_diff;
  logic [DENS_W-1:0]             dens;

  // Configuration registers
  logic [MV_W-1:0]    no_dust_r;
  logic [RATIO_W-1:0] ratio_r;
  logic               cfg_wr;

  // Sample ring
  logic [SAMPLE_W-1:0] ring_mem [WINDOW_LEN];

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_dust_r <= NO_DUST_RST;
      ratio_r   <= RATIO_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_NO_DUST: no_dust_r <= cfg_pwdata[MV_W-1:0];
        REG_RATIO:   ratio_r   <= cfg_pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_NO_DUST: cfg_prdata = {{(CFG_DW-MV_W){1'b0}}, no_dust_r};
      REG_RATIO:   cfg_prdata = {{(CFG_DW-RATIO_W){1'b0}}, ratio_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_AVG;
      ST_AVG:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_MV;
      ST_MV:    state_nxt = ST_DENS;
      ST_DENS:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SUM:   mem_we    = !first_pend_r;
      ST_DENS:  out_load  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign accept = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      wrapped_r    <= 1'b0;
      first_pend_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SUM) begin
        first_pend_r <= 1'b0;
        // The first sample fills the ring implicitly and leaves the slot alone
        if (!first_pend_r) begin
          if (slot_r == SLOT_W'(WINDOW_LEN - 1)) begin
            slot_r    <= '0;
            wrapped_r <= 1'b1;
          end else begin
            slot_r <= slot_r + SLOT_W'(1);
          end
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory: read on accept, write back during the sum step
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_r] <= sample_r;
    end
    if (accept) begin
      rdata_r <= ring_mem[slot_r];
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic
  // --------------------------------------------------------------------------
  // Before the first wrap every read hits an entry the first sample filled
  assign old_sample = wrapped_r ? rdata_r : first_r;

  always_comb begin
    if (first_pend_r) begin
      sum_nxt = SUM_W'({{(SUM_W-SAMPLE_W){1'b0}}, sample_r} * SUM_W'(WINDOW_LEN));
    end else begin
      sum_nxt = sum_r - {{(SUM_W-SAMPLE_W){1'b0}}, old_sample}
                      + {{(SUM_W-SAMPLE_W){1'b0}}, sample_r};
    end
  end

  assign avg_prod   = {{RECIP_W{1'b0}}, sum_r} * (SUM_W+RECIP_W)'(RECIP);
  assign scale_prod = {{REF_MV_W{1'b0}}, avg_r} * (SAMPLE_W+REF_MV_W)'(REF_MV);
  assign mv_nxt     = MV_W'({{(MV_W-SAMPLE_W){1'b0}}, scaled_r} * MV_W'(DIVIDER));
  assign mv_diff    = mv_r - no_dust_r;

  always_comb begin
    if (mv_r > no_dust_r) begin
      dens = {{(DENS_W-MV_W){1'b0}}, mv_diff} * {{(DENS_W-RATIO_W){1'b0}}, ratio_r};
    end else begin
      dens = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
      if (first_pend_r) begin
        first_r <= sample_r;
      end
    end
    if (state_r == ST_AVG) begin
      avg_r <= avg_prod[RECIP_SHIFT +: SAMPLE_W];
    end
    if (state_r == ST_SCALE) begin
      scaled_r <= scale_prod[ADC_SHIFT +: SAMPLE_W];
    end
    if (state_r == ST_MV) begin
      mv_r <= mv_nxt;
    end
    if (out_load) begin
      out_data_r <= {dens, mv_r, avg_r, sample_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DSAC_ASSERT(a_slot_in_ring, slot_r <= SLOT_W'(WINDOW_LEN - 1))
  `DSAC_ASSERT_NEXT(a_wrap_sticks, wrapped_r, wrapped_r)
  `DSAC_ASSERT_NEXT(a_first_done, state_r == ST_SUM, !first_pend_r)
  `DSAC_ASSERT_NEXT(a_accept_to_sum, accept, state_r == ST_SUM)
  `DSAC_ASSERT(a_mv_range, state_r == ST_DENS |-> mv_r <= MV_W'(MV_MAX))

endmodule
